@@ sv/sgtf_pkg.sv @@
package sgtf_pkg;

    // Channel count and the index width that addresses the offset table
    localparam int CHANNELS = 24;
    localparam int CH_IW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration port geometry
    localparam int REG_W     = 18;
    localparam int REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN = 2'd0,
        REG_BASE = 2'd1,
        REG_MAX  = 2'd2,
        REG_DEV  = 2'd3
    } reg_idx_t;

    // Register reset values
    localparam logic [17:0] GAIN_RESET = 18'd146677;
    localparam logic [11:0] BASE_RESET = 12'd600;
    localparam logic [11:0] MAX_RESET  = 12'd3000;
    localparam logic [6:0]  DEV_RESET  = 7'd12;

    // Frame header constants
    localparam logic [7:0] SYNC_BYTE  = 8'hAA;
    localparam logic [7:0] MULTI_BYTE = 8'h1F;

    // Input command codes
    localparam logic CMD_SET_OFFSET = 1'b0;
    localparam logic CMD_POSITION   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_CH  = 2'd1,
        ST_BAD_OFF = 2'd2,
        ST_BAD_GRP = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        JOB_STATUS = 2'd0,
        JOB_HEADER = 2'd1,
        JOB_TARGET = 2'd2
    } job_kind_t;

    // Beat positions within a header-plus-target frame
    localparam logic [2:0] BEAT_SYNC  = 3'd0;
    localparam logic [2:0] BEAT_DEV   = 3'd1;
    localparam logic [2:0] BEAT_CMD   = 3'd2;
    localparam logic [2:0] BEAT_COUNT = 3'd3;
    localparam logic [2:0] BEAT_START = 3'd4;
    localparam logic [2:0] BEAT_LO    = 3'd5;
    localparam logic [2:0] BEAT_HI    = 3'd6;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [17:0] gain_per_radian;
        logic [11:0] base_pulse;
        logic [11:0] max_pulse;
        logic [6:0]  device_number;
    } cfg_t;

    typedef struct packed {
        job_kind_t   kind;
        status_t     status;
        logic [4:0]  cnt;
        logic [4:0]  ch;
        logic [13:0] target;
    } job_t;

endpackage

@@ sv/sgtf_in_if.sv @@
interface sgtf_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [4:0]         channel;
    logic signed [12:0] offset_value;
    logic [4:0]         group_count;
    logic               first;
    logic signed [15:0] angle;

    modport source (
        output valid, cmd, channel, offset_value, group_count, first, angle,
        input  ready
    );
    modport sink (
        input  valid, cmd, channel, offset_value, group_count, first, angle,
        output ready
    );
endinterface

@@ sv/sgtf_out_if.sv @@
interface sgtf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       last;

    modport source (
        output valid, out_byte, byte_valid, status, last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, byte_valid, status, last,
        output ready
    );
endinterface

@@ sv/sgtf_front.sv @@
module sgtf_front (
    input  logic          clk,
    input  logic          rst_n,
    sgtf_in_if.sink       item,
    input  sgtf_pkg::cfg_t cfg,
    output sgtf_pkg::job_t job,
    output logic          job_valid,
    input  logic          job_ready
);
    import sgtf_pkg::*;

    // Offset table and group tracking
    logic signed [12:0] offset_reg [CHANNELS];
    logic [4:0] remaining_reg, remaining_next;
    logic [4:0] next_channel_reg, next_channel_next;
    logic       dropping_reg, dropping_next;

    // Stage A: classified item with offset looked up
    logic               a_valid_reg;
    job_kind_t          a_kind_reg;
    status_t            a_status_reg;
    logic [4:0]         a_cnt_reg;
    logic [4:0]         a_ch_reg;
    logic signed [15:0] a_angle_reg;
    logic signed [13:0] a_offb_reg;

    // Stage B: product registered
    logic               b_valid_reg;
    job_kind_t          b_kind_reg;
    status_t            b_status_reg;
    logic [4:0]         b_cnt_reg;
    logic [4:0]         b_ch_reg;
    logic signed [34:0] b_prod_reg;
    logic signed [13:0] b_offb_reg;

    logic b_adv, a_adv, accept;
    logic ch_ok, off_ok, cnt_ok, rd_ok, tbl_we;
    logic signed [13:0] off_in, max_s, offb;
    logic signed [12:0] rd_off;
    logic [4:0]  rd_ch;
    logic [5:0]  room;
    job_kind_t   kind;
    status_t     status;
    logic signed [34:0] prod;
    logic signed [35:0] sum;
    logic [17:0] t_raw;
    logic [13:0] lim, target;

    // Pipeline flow: each stage moves when the one after it frees up
    assign b_adv      = !b_valid_reg || job_ready;
    assign a_adv      = !a_valid_reg || b_adv;
    assign item.ready = a_adv;
    assign accept     = item.valid && a_adv;
    assign job_valid  = b_valid_reg;

    // Range checks on the incoming beat
    assign ch_ok  = {1'b0, item.channel} < 6'(CHANNELS);
    assign off_in = {item.offset_value[12], item.offset_value};
    assign max_s  = $signed({2'b00, cfg.max_pulse});
    assign off_ok = (off_in <= max_s) && (off_in >= -max_s);
    assign room   = 6'(CHANNELS) - {1'b0, item.channel};
    assign cnt_ok = (item.group_count != 5'd0) && ({1'b0, item.group_count} <= room);

    // Classify the beat and work out the group state that follows
    always_comb
    begin
        remaining_next    = remaining_reg;
        next_channel_next = next_channel_reg;
        dropping_next     = dropping_reg;
        tbl_we            = 1'b0;
        kind              = JOB_STATUS;
        status            = ST_OK;
        rd_ch             = next_channel_reg;
        if (item.cmd == CMD_SET_OFFSET)
        begin
            if (!ch_ok)
                status = ST_BAD_CH;
            else if (!off_ok)
                status = ST_BAD_OFF;
            else
                tbl_we = 1'b1;
        end
        else if (item.first)
        begin
            if (!ch_ok)
            begin
                status         = ST_BAD_CH;
                dropping_next  = 1'b1;
                remaining_next = 5'd0;
            end
            else if (!cnt_ok)
            begin
                status         = ST_BAD_GRP;
                dropping_next  = 1'b1;
                remaining_next = 5'd0;
            end
            else
            begin
                kind              = JOB_HEADER;
                dropping_next     = 1'b0;
                remaining_next    = item.group_count - 5'd1;
                next_channel_next = item.channel + 5'd1;
                rd_ch             = item.channel;
            end
        end
        else if (dropping_reg || (remaining_reg == 5'd0))
        begin
            status = ST_BAD_GRP;
        end
        else
        begin
            kind              = JOB_TARGET;
            remaining_next    = remaining_reg - 5'd1;
            next_channel_next = next_channel_reg + 5'd1;
        end
    end

    // Look up the offset; channels past the table read as zero
    assign rd_ok  = {1'b0, rd_ch} < 6'(CHANNELS);
    assign rd_off = rd_ok ? offset_reg[rd_ch[CH_IW-1:0]] : 13'sd0;
    assign offb   = $signed({rd_off[12], rd_off}) + $signed({2'b00, cfg.base_pulse});

    // Hold offsets and group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                offset_reg[i] <= '0;
            remaining_reg    <= '0;
            next_channel_reg <= '0;
            dropping_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (tbl_we)
                offset_reg[item.channel[CH_IW-1:0]] <= item.offset_value;
            remaining_reg    <= remaining_next;
            next_channel_reg <= next_channel_next;
            dropping_reg     <= dropping_next;
        end
    end

    // Stage A valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_adv)
            a_valid_reg <= item.valid;
    end

    // Stage A payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg   <= kind;
            a_status_reg <= status;
            a_cnt_reg    <= item.group_count;
            a_ch_reg     <= item.channel;
            a_angle_reg  <= item.angle;
            a_offb_reg   <= offb;
        end
    end

    // Angle times gain, Q20 microseconds
    assign prod = a_angle_reg * $signed({1'b0, cfg.gain_per_radian});

    // Stage B valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_adv)
            b_valid_reg <= a_valid_reg;
    end

    // Stage B payload
    always_ff @(posedge clk)
    begin
        if (b_adv && a_valid_reg)
        begin
            b_kind_reg   <= a_kind_reg;
            b_status_reg <= a_status_reg;
            b_cnt_reg    <= a_cnt_reg;
            b_ch_reg     <= a_ch_reg;
            b_prod_reg   <= prod;
            b_offb_reg   <= a_offb_reg;
        end
    end

    // Add the offset term, floor to quarter microseconds and clamp
    assign sum   = $signed({{2{b_offb_reg[13]}}, b_offb_reg, 20'd0})
                 + $signed({b_prod_reg[34], b_prod_reg});
    assign t_raw = sum[35:18];
    assign lim   = {cfg.max_pulse, 2'b00};

    always_comb
    begin
        if (sum[35])
            target = '0;
        else if (t_raw > {4'd0, lim})
            target = lim;
        else
            target = t_raw[13:0];
    end

    assign job.kind   = b_kind_reg;
    assign job.status = b_status_reg;
    assign job.cnt    = b_cnt_reg;
    assign job.ch     = b_ch_reg;
    assign job.target = target;

endmodule

@@ sv/sgtf_queue.sv @@
module sgtf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  sgtf_pkg::job_t push_job,
    input  logic           push_valid,
    output logic           push_ready,
    output sgtf_pkg::job_t head,
    output logic           head_valid,
    input  logic           pop
);
    import sgtf_pkg::*;

    job_t            mem [QUEUE_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            push, do_pop;

    assign push_ready = count_reg != (Q_AW + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign do_pop     = pop && head_valid;
    assign head       = mem[rd_ptr_reg];

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            if (push && !do_pop)
                count_reg <= count_reg + (Q_AW + 1)'(1);
            else if (do_pop && !push)
                count_reg <= count_reg - (Q_AW + 1)'(1);
        end
    end

endmodule

@@ sv/sgtf_back.sv @@
module sgtf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  sgtf_pkg::job_t head,
    input  logic           head_valid,
    output logic           pop,
    input  logic [6:0]     device_number,
    sgtf_out_if.source     result
);
    import sgtf_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic [2:0] beat;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       bv_reg, last_reg;
    logic [1:0] status_reg;
    logic [7:0] nx_byte;
    logic       nx_bv, nx_last;
    logic [1:0] nx_status;
    logic       load, take;

    // A target-only job starts at the low target byte
    assign beat = ((head.kind == JOB_TARGET) && (idx_reg == BEAT_SYNC)) ? BEAT_LO : idx_reg;

    // Decode the beat to send
    always_comb
    begin
        nx_byte   = '0;
        nx_bv     = 1'b1;
        nx_status = ST_OK;
        nx_last   = 1'b0;
        unique case (head.kind) inside
            JOB_HEADER, JOB_TARGET:
            begin
                unique case (beat)
                    BEAT_SYNC:  nx_byte = SYNC_BYTE;
                    BEAT_DEV:   nx_byte = {1'b0, device_number};
                    BEAT_CMD:   nx_byte = MULTI_BYTE;
                    BEAT_COUNT: nx_byte = {3'b000, head.cnt};
                    BEAT_START: nx_byte = {3'b000, head.ch};
                    BEAT_LO:    nx_byte = {1'b0, head.target[6:0]};
                    BEAT_HI:
                    begin
                        nx_byte = {1'b0, head.target[13:7]};
                        nx_last = 1'b1;
                    end
                    default:
                    begin
                        nx_byte = '0;
                        nx_last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                nx_bv     = 1'b0;
                nx_status = head.status;
                nx_last   = 1'b1;
            end
        endcase
    end

    assign load     = !out_valid_reg || result.ready;
    assign take     = load && head_valid;
    assign pop      = take && nx_last;
    assign idx_next = nx_last ? BEAT_SYNC : beat + 3'd1;

    // Advance the beat counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= BEAT_SYNC;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= head_valid;
            if (head_valid)
                idx_reg <= idx_next;
        end
    end

    // Load the output beat
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg   <= nx_byte;
            bv_reg     <= nx_bv;
            status_reg <= nx_status;
            last_reg   <= nx_last;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = byte_reg;
    assign result.byte_valid = bv_reg;
    assign result.status     = status_reg;
    assign result.last       = last_reg;

endmodule

@@ sv/servo_group_target_framer.sv @@
// An item's first result beat passes stage A, stage B, the job queue and the output
// beat register. The byte serialiser sends one beat per cycle unless result.ready
// stalls it; a position element is 2 beats, a group's first 7, a rejected or
// set-offset item 1. The front takes one item per cycle until the four-entry job
// queue fills. Reset (rst_n, asynchronous, active low) restores register defaults,
// clears the offset table and group state, and empties the pipeline and queue.
module servo_group_target_framer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sgtf_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [sgtf_pkg::REG_W-1:0]     cfg_data,
    sgtf_in_if.sink                        item,
    sgtf_out_if.source                     result
);
    import sgtf_pkg::*;

    cfg_t cfg_reg;
    job_t fq_job, head;
    logic fq_valid, fq_ready, head_valid, pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_per_radian <= GAIN_RESET;
            cfg_reg.base_pulse      <= BASE_RESET;
            cfg_reg.max_pulse       <= MAX_RESET;
            cfg_reg.device_number   <= DEV_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_GAIN: cfg_reg.gain_per_radian <= cfg_data;
                REG_BASE: cfg_reg.base_pulse      <= cfg_data[11:0];
                REG_MAX:  cfg_reg.max_pulse       <= cfg_data[11:0];
                REG_DEV:  cfg_reg.device_number   <= cfg_data[6:0];
            endcase
        end
    end

    sgtf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg_reg),
        .job       (fq_job),
        .job_valid (fq_valid),
        .job_ready (fq_ready)
    );

    sgtf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (fq_job),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    sgtf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .device_number (cfg_reg.device_number),
        .result        (result)
    );

endmodule

@@ sv/sgtf_checker.sv @@
module sgtf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       r_valid,
    input logic       r_ready,
    input logic [7:0] r_byte,
    input logic       r_bv,
    input logic [1:0] r_status,
    input logic       r_last
);
    import sgtf_pkg::*;

    // A stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_byte) && $stable(r_last))
        else $error("stalled result beat changed");

    // A beat with no byte closes its item and carries a zero byte
    a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_bv |-> r_last && (r_byte == 8'd0))
        else $error("status-only beat malformed");

    // Frame bytes only come with an ok status
    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_bv |-> r_status == ST_OK)
        else $error("frame byte with error status");

    // The sync byte is never the last beat of an item
    a_sync: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_bv && (r_byte == SYNC_BYTE) |-> !r_last)
        else $error("sync byte ended an item");

endmodule

bind servo_group_target_framer sgtf_checker u_sgtf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .r_valid  (result.valid),
    .r_ready  (result.ready),
    .r_byte   (result.out_byte),
    .r_bv     (result.byte_valid),
    .r_status (result.status),
    .r_last   (result.last)
);
